FILE: hw/rtl/prd_pkg.sv
// Shared types and constants for the pulse rate detector.
package prd_pkg;

    // Field widths
    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 18;
    localparam int FRAC_W      = 8;
    localparam int RATE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Filter coefficients: 218/256 keep, 38/256 take
    localparam logic [7:0] FILT_KEEP = 8'd218;
    localparam logic [5:0] FILT_TAKE = 6'd38;

    // Rate arithmetic
    localparam logic [15:0]       MS_PER_MINUTE = 16'd60000;
    localparam logic [TIME_W-1:0] INIT_INTERVAL = 32'd1000;
    localparam logic [RATE_W-1:0] RATE_MAX      = 8'd255;

    // Rate divider: one quotient bit per cycle
    localparam int DIV_W      = 32;
    localparam int DIV_ITER_W = 6;
    localparam logic [DIV_ITER_W-1:0] ITER_RATE = 6'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH  = 3'd4;

    // Register reset values
    localparam logic [15:0]         RST_REFRACTORY = 16'd300;
    localparam logic [SAMPLE_W-1:0] RST_BEAT_MIN   = 10'd100;
    localparam logic [SAMPLE_W-1:0] RST_PRESENT    = 10'd575;
    localparam logic [RATE_W-1:0]   RST_RATE_LOW   = 8'd50;
    localparam logic [RATE_W-1:0]   RST_RATE_HIGH  = 8'd100;

    typedef struct packed {
        logic [15:0]         refractory_ms;
        logic [SAMPLE_W-1:0] beat_min_level;
        logic [SAMPLE_W-1:0] present_level;
        logic [RATE_W-1:0]   rate_low_limit;
        logic [RATE_W-1:0]   rate_high_limit;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic filt;
        logic decide;
        logic avg_load;
        logic div_rate_start;
        logic rate_sat;
        logic rate_load;
        logic alarm_upd;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic beat;
        logic div_done;
        logic avg_zero;
    } status_t;

endpackage

FILE: hw/rtl/prd_div.sv
// Restoring divider, one quotient bit per cycle, iteration count set at start.
module prd_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [prd_pkg::DIV_W-1:0]      dividend,
    input  logic [prd_pkg::DIV_W-1:0]      divisor,
    input  logic [prd_pkg::DIV_ITER_W-1:0] iterations,
    output logic [prd_pkg::DIV_W-1:0]      quotient,
    output logic                           done
);
    import prd_pkg::*;

    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [DIV_W-1:0]      dsr_reg, dsr_next;
    logic [DIV_ITER_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_W:0]        trial;
    logic [DIV_W:0]        diff;
    logic                  fits;

    // One compare and subtract step
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = iterations;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: hw/rtl/prd_datapath.sv
// Filter, beat decision, interval history, rate and alarm datapath.
module prd_datapath
#(
    parameter int HISTORY_DEPTH = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  prd_pkg::cmd_t                  cmd,
    output prd_pkg::status_t               status,
    input  prd_pkg::cfg_t                  cfg,
    input  logic [prd_pkg::SAMPLE_W-1:0]   sample,
    input  logic [prd_pkg::TIME_W-1:0]     time_ms,
    output logic [prd_pkg::LEVEL_W-1:0]    filtered_level,
    output logic                           beat,
    output logic [prd_pkg::RATE_W-1:0]     rate,
    output logic                           signal_present,
    output logic                           alarm
);
    import prd_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [TIME_W-1:0] SUM_INIT = TIME_W'(1000 * HISTORY_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    // Sum over depth as a reciprocal multiply: ceil(2^(32+l)/depth), l = clog2(depth)
    localparam int AVG_SHIFT = TIME_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W   = TIME_W + 1;
    localparam int PROD_W    = AVG_SHIFT + TIME_W;
    localparam logic [63:0] AVG_NUM = 64'd1 << AVG_SHIFT;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((AVG_NUM + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH));

    // Item and state registers
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [LEVEL_W-1:0]  filter_reg, filter_next;
    logic [LEVEL_W-1:0]  prev_reg, prev_next;
    logic                armed_off_reg, armed_off_next;
    logic [TIME_W-1:0]   last_beat_reg, last_beat_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   ring_reg [HISTORY_DEPTH];
    logic [TIME_W-1:0]   ring_next [HISTORY_DEPTH];
    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic [TIME_W-1:0]   sum_reg, sum_next;
    logic [TIME_W-1:0]   avg_reg, avg_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic                alarm_reg, alarm_next;
    logic                beat_reg, beat_next;
    logic                present_reg, present_next;

    // Output register
    logic [LEVEL_W-1:0]  o_level_reg, o_level_next;
    logic                o_beat_reg, o_beat_next;
    logic [RATE_W-1:0]   o_rate_reg, o_rate_next;
    logic                o_present_reg, o_present_next;
    logic                o_alarm_reg, o_alarm_next;

    // Filter arithmetic
    logic [25:0]         keep_prod;
    logic [15:0]         take_prod;
    logic [26:0]         filt_sum;
    logic                beat_ok;

    // Average arithmetic
    logic [PROD_W-1:0]   avg_prod;

    // Divider hookup
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic [DIV_ITER_W-1:0] div_iter;
    logic [DIV_W-1:0]    div_quo;
    logic                div_done;
    logic [DIV_W-2:0]    half_rate;

    assign keep_prod = {18'b0, FILT_KEEP} * {8'b0, filter_reg};
    assign take_prod = {10'b0, FILT_TAKE} * {6'b0, sample_reg};
    assign filt_sum  = {1'b0, keep_prod} + {3'b0, take_prod, 8'b0};

    assign beat_ok = (filter_reg > prev_reg) && !armed_off_reg &&
                     (elapsed_reg > {16'b0, cfg.refractory_ms}) &&
                     (filter_reg > {cfg.beat_min_level, {FRAC_W{1'b0}}});

    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);

    // Average by multiply, then minute over average on the divider
    assign div_start    = cmd.div_rate_start;
    assign div_dividend = {MS_PER_MINUTE, 16'b0};
    assign div_divisor  = avg_reg;
    assign div_iter     = ITER_RATE;
    assign half_rate    = div_quo[DIV_W-1:1];

    prd_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .iterations (div_iter),
        .quotient   (div_quo),
        .done       (div_done)
    );

    always_comb
    begin
        sample_next    = sample_reg;
        time_next      = time_reg;
        filter_next    = filter_reg;
        prev_next      = prev_reg;
        armed_off_next = armed_off_reg;
        last_beat_next = last_beat_reg;
        elapsed_next   = elapsed_reg;
        ring_next      = ring_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        rate_next      = rate_reg;
        alarm_next     = alarm_reg;
        beat_next      = beat_reg;
        present_next   = present_reg;
        o_level_next   = o_level_reg;
        o_beat_next    = o_beat_reg;
        o_rate_next    = o_rate_reg;
        o_present_next = o_present_reg;
        o_alarm_next   = o_alarm_reg;

        // Capture the request
        if (cmd.load_in)
        begin
            sample_next = sample;
            time_next   = time_ms;
        end

        // Filter update and time since last beat
        if (cmd.filt)
        begin
            filter_next  = filt_sum[FRAC_W +: LEVEL_W];
            elapsed_next = time_reg - last_beat_reg;
        end

        // Beat decision and history update
        if (cmd.decide)
        begin
            beat_next = beat_ok;
            if (beat_ok)
            begin
                armed_off_next     = 1'b1;
                last_beat_next     = time_reg;
                ring_next[pos_reg] = elapsed_reg;
                sum_next           = sum_reg - ring_reg[pos_reg] + elapsed_reg;
                pos_next           = (pos_reg == PTR_LAST) ? '0 : pos_reg + 1'b1;
            end
            if (filter_reg < prev_reg)
                armed_off_next = 1'b0;
            prev_next    = filter_reg;
            present_next = filter_reg > {cfg.present_level, {FRAC_W{1'b0}}};
        end

        // Average interval over the history
        if (cmd.avg_load)
            avg_next = avg_prod[AVG_SHIFT +: TIME_W];

        // Rate: zero average saturates, otherwise halve and clamp
        if (cmd.rate_sat)
            rate_next = RATE_MAX;
        else if (cmd.rate_load)
            rate_next = (half_rate > (DIV_W-1)'(RATE_MAX)) ? RATE_MAX
                                                           : half_rate[RATE_W-1:0];

        // Alarm held while no signal
        if (cmd.alarm_upd && present_reg)
            alarm_next = (rate_reg > cfg.rate_high_limit) ||
                         (rate_reg < cfg.rate_low_limit);

        if (cmd.out_load)
        begin
            o_level_next   = filter_reg;
            o_beat_next    = beat_reg;
            o_rate_next    = rate_reg;
            o_present_next = present_reg;
            o_alarm_next   = alarm_reg;
        end
    end

    // Detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg    <= '0;
            prev_reg      <= '0;
            armed_off_reg <= 1'b0;
            last_beat_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                ring_reg[i] <= INIT_INTERVAL;
            pos_reg       <= '0;
            sum_reg       <= SUM_INIT;
            rate_reg      <= '0;
            alarm_reg     <= 1'b0;
        end
        else
        begin
            filter_reg    <= filter_next;
            prev_reg      <= prev_next;
            armed_off_reg <= armed_off_next;
            last_beat_reg <= last_beat_next;
            ring_reg      <= ring_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            rate_reg      <= rate_next;
            alarm_reg     <= alarm_next;
        end
    end

    // Per-request payload
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        time_reg      <= time_next;
        elapsed_reg   <= elapsed_next;
        avg_reg       <= avg_next;
        beat_reg      <= beat_next;
        present_reg   <= present_next;
        o_level_reg   <= o_level_next;
        o_beat_reg    <= o_beat_next;
        o_rate_reg    <= o_rate_next;
        o_present_reg <= o_present_next;
        o_alarm_reg   <= o_alarm_next;
    end

    assign status.beat     = beat_reg;
    assign status.div_done = div_done;
    assign status.avg_zero = (avg_reg == '0);

    assign filtered_level = o_level_reg;
    assign beat           = o_beat_reg;
    assign rate           = o_rate_reg;
    assign signal_present = o_present_reg;
    assign alarm          = o_alarm_reg;

endmodule

FILE: hw/rtl/prd_ctrl.sv
// Sequencing state machine for the pulse rate detector.
module prd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  prd_pkg::status_t status,
    output prd_pkg::cmd_t    cmd
);
    import prd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FILT     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_BRANCH   = 3'd3;
    localparam logic [2:0] S_AVG      = 3'd4;
    localparam logic [2:0] S_DIV_RATE = 3'd5;
    localparam logic [2:0] S_ALARM    = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_FILT;
                end
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (status.beat)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = S_AVG;
                end
                else
                    state_next = S_ALARM;
            end
            S_AVG:
            begin
                if (status.avg_zero)
                begin
                    cmd.rate_sat = 1'b1;
                    state_next   = S_ALARM;
                end
                else
                begin
                    cmd.div_rate_start = 1'b1;
                    state_next         = S_DIV_RATE;
                end
            end
            S_DIV_RATE:
            begin
                if (status.div_done)
                begin
                    cmd.rate_load = 1'b1;
                    state_next    = S_ALARM;
                end
            end
            S_ALARM:
            begin
                cmd.alarm_upd = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/pulse_rate_detector.sv
// Pulse rate detector top level: configuration registers, controller and datapath.
//
// Usage: each input request carries one 10-bit sample and its millisecond
// timestamp on a valid/ready channel; each produces exactly one result
// request (filtered level, beat flag, rate, signal present, alarm) on a
// valid/ready output channel. Configuration registers are written through
// cfg_write/cfg_index/cfg_data while the block is idle; unknown indexes
// are ignored.
// Flow: a sample that is not a beat passes the filter, decision, branch,
// alarm and output states. A beat averages the interval history with a
// reciprocal multiply, then runs the one-bit-per-cycle divider for 16 steps
// to get the rate; when the average is zero the rate saturates instead.
// One request is processed at a time and the next can be taken in the cycle
// after the result is loaded.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next result waits in the final
// state until the output register frees up.
// Reset clears the filter, the beat state and the alarm, fills the interval
// history with 1000 ms and restores the register defaults.
module pulse_rate_detector
#(
    parameter int HISTORY_DEPTH = 5
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [prd_pkg::SAMPLE_W-1:0]     sample,
    input  logic [prd_pkg::TIME_W-1:0]       time_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [prd_pkg::LEVEL_W-1:0]      filtered_level,
    output logic                             beat,
    output logic [prd_pkg::RATE_W-1:0]       rate,
    output logic                             signal_present,
    output logic                             alarm,
    input  logic                             cfg_write,
    input  logic [prd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import prd_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REFRACTORY: cfg_next.refractory_ms   = cfg_data;
                REG_BEAT_MIN:   cfg_next.beat_min_level  = cfg_data[SAMPLE_W-1:0];
                REG_PRESENT:    cfg_next.present_level   = cfg_data[SAMPLE_W-1:0];
                REG_RATE_LOW:   cfg_next.rate_low_limit  = cfg_data[RATE_W-1:0];
                REG_RATE_HIGH:  cfg_next.rate_high_limit = cfg_data[RATE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refractory_ms   <= RST_REFRACTORY;
            cfg_reg.beat_min_level  <= RST_BEAT_MIN;
            cfg_reg.present_level   <= RST_PRESENT;
            cfg_reg.rate_low_limit  <= RST_RATE_LOW;
            cfg_reg.rate_high_limit <= RST_RATE_HIGH;
        end
        else
            cfg_reg <= cfg_next;
    end

    prd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    prd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg_reg),
        .sample         (sample),
        .time_ms        (time_ms),
        .filtered_level (filtered_level),
        .beat           (beat),
        .rate           (rate),
        .signal_present (signal_present),
        .alarm          (alarm)
    );

endmodule

FILE: hw/rtl/prd_checker.sv
// Port-level checks for the pulse rate detector, bound to the top level.
module prd_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [prd_pkg::LEVEL_W-1:0]  filtered_level,
    input logic                         beat,
    input logic [prd_pkg::RATE_W-1:0]   rate,
    input logic                         signal_present,
    input logic                         alarm
);
    import prd_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(filtered_level) && $stable(beat) &&
        $stable(rate) && $stable(signal_present) && $stable(alarm))
        else $error("result changed while stalled");

    // One request in flight: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while busy");

    // A reported beat needs a nonzero filtered level
    a_beat_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beat |-> filtered_level != '0)
        else $error("beat reported at zero level");

endmodule

bind pulse_rate_detector prd_checker u_prd_checker (.*);

FILE: bench/pulse_rate_detector_test.sv
// Self-checking bench for the pulse rate detector: directed table, then random pulse trains.
module pulse_rate_detector_test;
    import prd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int HIST_DEPTH       = 5;
    localparam int SAMPLE_MAX       = 1023;
    localparam int RAND_PHASES      = 8;
    localparam int RAND_PER_PHASE   = 150;
    localparam int IDLE_SLACK       = 4;
    localparam int END_SLACK        = 64;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TIMEOUT_CYCLES   = 1500000;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] filtered_level;
        logic               beat;
        logic [RATE_W-1:0]  rate;
        logic               present;
        logic               alarm;
    } report_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    smp;
        logic [TIME_W-1:0]      stamp;
        logic                   typed;
        report_t                want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample;
    logic [TIME_W-1:0]      time_ms;
    logic                   out_valid;
    logic                   out_ready;
    logic [LEVEL_W-1:0]     filtered_level;
    logic                   beat;
    logic [RATE_W-1:0]      rate;
    logic                   signal_present;
    logic                   alarm;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the block state and its registers
    cfg_t                   settings;
    logic [LEVEL_W-1:0]     flt_level;
    logic [LEVEL_W-1:0]     flt_prev;
    logic                   pulse_held;
    logic [TIME_W-1:0]      last_beat_ms;
    logic [TIME_W-1:0]      interval_hist [HIST_DEPTH];
    int                     hist_pos;
    logic [TIME_W-1:0]      hist_sum;
    logic [RATE_W-1:0]      rate_bpm;
    logic                   alarm_held;

    report_t                pending_reports [$];
    report_t                oldest_report;
    stim_row_t              stim_rows [$];

    int items_sent;
    int results_seen;
    int beats_seen;
    int present_seen;
    int alarms_seen;
    int fail_count;

    pulse_rate_detector
    #(
        .HISTORY_DEPTH(HIST_DEPTH)
    )
    DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .time_ms(time_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .filtered_level(filtered_level),
        .beat(beat),
        .rate(rate),
        .signal_present(signal_present),
        .alarm(alarm),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Advance the predicted state by one sample and return the report it produces
    function automatic report_t compute_report(input logic [SAMPLE_W-1:0] s,
                                               input logic [TIME_W-1:0] t);
        logic [31:0]        acc;
        logic [LEVEL_W-1:0] f;
        logic [31:0]        elapsed;
        logic [31:0]        avg;
        logic [31:0]        bpm;
        report_t            rep;
        acc = {24'd0, FILT_KEEP} * {14'd0, flt_level}
            + (({26'd0, FILT_TAKE} * {22'd0, s}) << FRAC_W);
        f = acc[LEVEL_W+FRAC_W-1:FRAC_W];
        flt_level = f;
        elapsed = t - last_beat_ms;
        rep.beat = 1'b0;
        if (f > flt_prev && !pulse_held && elapsed > {16'd0, settings.refractory_ms}
            && f > {settings.beat_min_level, 8'd0})
        begin
            rep.beat = 1'b1;
            pulse_held = 1'b1;
            last_beat_ms = t;
            // ring of intervals with a running sum, both wrapping at 32 bits
            hist_sum = hist_sum - interval_hist[hist_pos] + elapsed;
            interval_hist[hist_pos] = elapsed;
            hist_pos = (hist_pos == HIST_DEPTH - 1) ? 0 : hist_pos + 1;
            avg = hist_sum / HIST_DEPTH;
            if (avg == 0)
                rate_bpm = RATE_MAX;
            else
            begin
                bpm = ({16'd0, MS_PER_MINUTE} / avg) / 2;
                rate_bpm = (bpm > 32'd255) ? RATE_MAX : bpm[RATE_W-1:0];
            end
        end
        if (f < flt_prev)
            pulse_held = 1'b0;
        flt_prev = f;
        rep.present = f > {settings.present_level, 8'd0};
        // alarm only moves while the signal is present
        if (rep.present)
            alarm_held = (rate_bpm > settings.rate_high_limit)
                      || (rate_bpm < settings.rate_low_limit);
        rep.filtered_level = f;
        rep.rate = rate_bpm;
        rep.alarm = alarm_held;
        return rep;
    endfunction

    // Directed table entries
    function automatic void push_sample(input int s, input logic [TIME_W-1:0] t);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.smp = SAMPLE_W'(s);
        row.stamp = t;
        stim_rows.push_back(row);
    endfunction

    function automatic void push_checked(input int s, input logic [TIME_W-1:0] t,
                                         input int f, input int b, input int r,
                                         input int p, input int a);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.smp = SAMPLE_W'(s);
        row.stamp = t;
        row.typed = 1'b1;
        row.want.filtered_level = LEVEL_W'(f);
        row.want.beat = 1'(b);
        row.want.rate = RATE_W'(r);
        row.want.present = 1'(p);
        row.want.alarm = 1'(a);
        stim_rows.push_back(row);
    endfunction

    function automatic void push_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        stim_rows.push_back(row);
    endfunction

    // Register value for a random phase: all-min, all-max, or mostly realistic
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int phase, input int top,
                                                           input int lo, input int hi);
        int                     roll;
        logic [CFG_DATA_W-1:0]  val;
        roll = $urandom_range(0, 99);
        if (phase == 1 || roll < 12)
            val = '0;
        else if (phase == 2 || roll < 24)
            val = CFG_DATA_W'(top);
        else if (roll < 34)
            val = CFG_DATA_W'($urandom_range(0, top));
        else
            val = CFG_DATA_W'($urandom_range(lo, hi));
        // bits above the register width must be dropped by the block
        val = val | CFG_DATA_W'($urandom & ~top);
        return val;
    endfunction

    function automatic int sender_gap(input bit full_rate);
        int roll;
        roll = $urandom_range(0, 99);
        if (full_rate || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one request and log its predicted report once accepted
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t,
                                input logic typed, input report_t want);
        report_t rep;
        sample <= s;
        time_ms <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rep = compute_report(s, t);
        pending_reports.push_back(typed ? want : rep);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(input bit full_rate);
        int gap;
        gap = sender_gap(full_rate);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained(input int slack);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (slack) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_REFRACTORY: settings.refractory_ms = data;
            REG_BEAT_MIN:   settings.beat_min_level = data[SAMPLE_W-1:0];
            REG_PRESENT:    settings.present_level = data[SAMPLE_W-1:0];
            REG_RATE_LOW:   settings.rate_low_limit = data[RATE_W-1:0];
            REG_RATE_HIGH:  settings.rate_high_limit = data[RATE_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            beats_seen += int'(beat);
            present_seen += int'(signal_present);
            alarms_seen += int'(alarm);
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual level %0d",
                         $time, filtered_level);
                fail_count++;
            end
            else
            begin
                oldest_report = pending_reports.pop_front();
                check_field("filtered_level", 32'(oldest_report.filtered_level),
                            32'(filtered_level));
                check_field("beat", 32'(oldest_report.beat), 32'(beat));
                check_field("rate", 32'(oldest_report.rate), 32'(rate));
                check_field("signal_present", 32'(oldest_report.present),
                            32'(signal_present));
                check_field("alarm", 32'(oldest_report.alarm), 32'(alarm));
            end
        end
    end

    // Receiver: random ready pattern plus one long hold-off to back up the block
    initial
    begin : receiver
        int pick;
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                span = LONG_HOLD_CYCLES;
            end
            else if (pick < 50)
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 80);
            end
            else if (pick < 85)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                span = $urandom_range(10, 60);
            end
            repeat (span) @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        stim_row_t          row;
        logic [TIME_W-1:0]  now_ms;
        logic [9:0]         wave_level;
        logic [9:0]         smp;
        bit                 wave_up;
        int                 wave_left;
        int                 roll;
        bit                 full_rate;

        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        time_ms = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        results_seen = 0;
        beats_seen = 0;
        present_seen = 0;
        alarms_seen = 0;
        fail_count = 0;

        // predictor reset state
        settings = {RST_REFRACTORY, RST_BEAT_MIN, RST_PRESENT, RST_RATE_LOW, RST_RATE_HIGH};
        flt_level = '0;
        flt_prev = '0;
        pulse_held = 1'b0;
        last_beat_ms = '0;
        foreach (interval_hist[i])
            interval_hist[i] = INIT_INTERVAL;
        hist_pos = 0;
        hist_sum = INIT_INTERVAL * HIST_DEPTH;
        rate_bpm = '0;
        alarm_held = 1'b0;

        // Default registers: first beat, filter climbing into presence with a low-rate
        // alarm, then the alarm held while the level falls below presence, and a beat
        // whose interval wraps the timestamp and the running sum
        push_checked(0, 0, 0, 0, 0, 0, 0);
        push_checked(SAMPLE_MAX, 1000, 38874, 1, 30, 0, 0);
        for (int k = 1; k <= 6; k++)
            push_sample(SAMPLE_MAX, 1000 + 100 * k);
        push_sample(0, 1700);
        push_sample(0, 1800);
        push_sample(0, 1900);
        push_sample(SAMPLE_MAX, 32'hFFFF_FFFF);
        push_sample(0, 0);

        // Writes to unused indexes must do nothing; then every register at an extreme
        push_write(REG_SPARE_LO, 16'hFFFF);
        push_write(REG_SPARE_HI, 16'h0001);
        push_write(REG_REFRACTORY, 16'd0);
        push_write(REG_BEAT_MIN, 16'd0);
        push_write(REG_PRESENT, 16'd0);
        push_write(REG_RATE_LOW, 16'd0);
        push_write(REG_RATE_HIGH, 16'hFFFF);

        // One-millisecond intervals saturate the rate; a step back in time then
        // wraps the sum to below one average unit
        for (int k = 0; k < 6; k++)
        begin
            push_sample(SAMPLE_MAX, 5000 + k);
            push_sample(0, 5000 + k);
        end
        push_sample(SAMPLE_MAX, 5004);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained(IDLE_SLACK);
                write_reg(row.idx, row.data);
            end
            else
            begin
                offer_sample(row.smp, row.stamp, row.typed, row.want);
                pause_sender(1'b0);
            end
        end

        // Random pulse trains with noise, time jumps and backward steps
        now_ms = 32'd6000;
        wave_up = 1'b0;
        wave_left = 0;
        wave_level = '0;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_drained(IDLE_SLACK);
            write_reg(REG_REFRACTORY, pick_setting(phase, 16'hFFFF, 0, 600));
            write_reg(REG_BEAT_MIN, pick_setting(phase, 10'h3FF, 0, 400));
            write_reg(REG_PRESENT, pick_setting(phase, 10'h3FF, 0, 800));
            write_reg(REG_RATE_LOW, pick_setting(phase, 8'hFF, 0, 120));
            write_reg(REG_RATE_HIGH, pick_setting(phase, 8'hFF, 60, 255));
            full_rate = (phase % 3 == 0);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (wave_left == 0)
                begin
                    wave_up = !wave_up;
                    wave_left = $urandom_range(1, 6);
                    wave_level = wave_up ? SAMPLE_W'($urandom_range(500, SAMPLE_MAX))
                                         : SAMPLE_W'($urandom_range(0, 300));
                end
                wave_left--;
                roll = $urandom_range(0, 99);
                smp = (roll < 10) ? SAMPLE_W'($urandom_range(0, SAMPLE_MAX)) : wave_level;
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    now_ms = $urandom;
                else if (roll < 5)
                    now_ms = now_ms - $urandom_range(1, 3000);
                else
                    now_ms = now_ms + $urandom_range(10, 250);
                offer_sample(smp, now_ms, 1'b0, '0);
                pause_sender(full_rate);
            end
        end

        wait_drained(END_SLACK);
        if (pending_reports.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_reports.size());
            fail_count++;
        end
        $display("Checked %0d results for %0d samples: %0d beats, %0d present, %0d alarmed",
                 results_seen, items_sent, beats_seen, present_seen, alarms_seen);
        $display("Ran %0d register settings, including all-minimum and all-maximum",
                 RAND_PHASES + 1);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timed out with %0d results outstanding", pending_reports.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/prd_pkg.sv
hw/rtl/prd_div.sv
hw/rtl/prd_datapath.sv
hw/rtl/prd_ctrl.sv
hw/rtl/pulse_rate_detector.sv
hw/rtl/prd_checker.sv
bench/pulse_rate_detector_test.sv
